>>> rtl/core/stsmc_pkg.sv
// Shared constants and register codes for the super-twisting controller.
`default_nettype none
package stsmc_pkg;

   localparam int unsigned DATA_W    = 32;
   localparam int unsigned PERIOD_W  = 31;
   localparam int unsigned ADDR_W    = 5;
   localparam int unsigned DIVD_W    = 49;
   localparam int unsigned RAD_W     = 48;
   localparam int unsigned ROOT_W    = RAD_W / 2;

   localparam logic [DATA_W-1:0]   RST_SLOPE     = 32'd65536;
   localparam logic [DATA_W-1:0]   RST_ROOT_GAIN = 32'd65536;
   localparam logic [DATA_W-1:0]   RST_SIGN_GAIN = 32'd131072;
   localparam logic [PERIOD_W-1:0] RST_PERIOD    = 31'd66;
   localparam logic [DATA_W-1:0]   RST_LOW_LIM   = 32'hFF9C_0000;
   localparam logic [DATA_W-1:0]   RST_HIGH_LIM  = 32'h0064_0000;
   localparam logic [PERIOD_W-1:0] FALLBACK_PERIOD = 31'd66;
   localparam logic [PERIOD_W-1:0] Q_ONE         = 31'd65536;

   typedef enum logic [2:0] {
      REG_SLOPE     = 3'd0,
      REG_ROOT_GAIN = 3'd1,
      REG_SIGN_GAIN = 3'd2,
      REG_PERIOD    = 3'd3,
      REG_LOW_LIM   = 3'd4,
      REG_HIGH_LIM  = 3'd5,
      REG_VEL_MODE  = 3'd6
   } reg_index_type;

endpackage
`default_nettype wire

>>> rtl/core/stsmc_if.sv
// Request and response channel interfaces of the super-twisting controller.
`default_nettype none
interface stsmc_req_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] reference;
   logic signed [31:0] measurement;
   logic signed [31:0] velocity;
   modport source (output valid, reference, measurement, velocity, input ready);
   modport sink   (input valid, reference, measurement, velocity, output ready);
endinterface

interface stsmc_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] control;
   logic signed [31:0] sliding_surface;
   modport source (output valid, control, sliding_surface, input ready);
   modport sink   (input valid, control, sliding_surface, output ready);
endinterface
`default_nettype wire

>>> rtl/core/stsmc_div.sv
// Restoring divider, one quotient bit per cycle.
`default_nettype none
module stsmc_div (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   input  wire logic [stsmc_pkg::DIVD_W-1:0]   dividend,
   input  wire logic [stsmc_pkg::PERIOD_W-1:0] divisor,
   output logic                               done,
   output logic [stsmc_pkg::DIVD_W-1:0]        quotient
);
   import stsmc_pkg::*;

   logic                  busy_ff, done_ff;
   logic [5:0]            cnt_ff;
   logic [PERIOD_W-1:0]   rem_ff, rem_in, div_ff;
   logic [DIVD_W-1:0]     quo_ff;
   logic [PERIOD_W:0]     trial;
   logic                  ge;

   always_comb begin
      trial  = {rem_ff, quo_ff[DIVD_W-1]};
      ge     = trial >= {1'b0, div_ff};
      rem_in = ge ? PERIOD_W'(trial - {1'b0, div_ff}) : trial[PERIOD_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= 6'(DIVD_W - 1);
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - 6'd1;
            if (cnt_ff == 6'd0) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= '0;
         quo_ff <= dividend;
         div_ff <= divisor;
      end else if (busy_ff) begin
         rem_ff <= rem_in;
         quo_ff <= {quo_ff[DIVD_W-2:0], ge};
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;
endmodule
`default_nettype wire

>>> rtl/core/stsmc_sqrt.sv
// Floored integer square root, one result bit per cycle.
`default_nettype none
module stsmc_sqrt (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        start,
   input  wire logic [stsmc_pkg::RAD_W-1:0]  radicand,
   output logic                             done,
   output logic [stsmc_pkg::ROOT_W-1:0]      root
);
   import stsmc_pkg::*;

   logic                 busy_ff, done_ff;
   logic [4:0]           cnt_ff;
   logic [RAD_W-1:0]     rad_ff;
   logic [ROOT_W+1:0]    rem_ff, rem_in;
   logic [ROOT_W-1:0]    root_ff;
   logic [ROOT_W+3:0]    remsh;
   logic [ROOT_W+1:0]    trial;
   logic                 ge;

   always_comb begin
      remsh  = {rem_ff, rad_ff[RAD_W-1:RAD_W-2]};
      trial  = {root_ff, 2'b01};
      ge     = remsh >= {2'b00, trial};
      rem_in = ge ? (ROOT_W+2)'(remsh - {2'b00, trial}) : remsh[ROOT_W+1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= 5'(ROOT_W - 1);
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - 5'd1;
            if (cnt_ff == 5'd0) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rad_ff  <= radicand;
         rem_ff  <= '0;
         root_ff <= '0;
      end else if (busy_ff) begin
         rad_ff  <= {rad_ff[RAD_W-3:0], 2'b00};
         rem_ff  <= rem_in;
         root_ff <= {root_ff[ROOT_W-2:0], ge};
      end
   end

   assign done = done_ff;
   assign root = root_ff;
endmodule
`default_nettype wire

>>> rtl/core/super_twisting_sliding_mode_control.sv
// Top level of the super-twisting sliding mode controller.
// A request takes longer in difference mode, which waits on the divider,
// and is shortest when the surface is zero, which skips the square root.
// One request is handled at a time; the next is taken from the cycle in which
// the response is raised, after any stall on the response side.
// Reset (synchronous, active high) restores the register defaults and clears
// both integrators, the stored measurement and the response channel.
`default_nettype none
module super_twisting_sliding_mode_control (
   input  wire logic                          clock,
   input  wire logic                          reset,
   stsmc_req_if.sink                          req,
   stsmc_rsp_if.source                        rsp,
   input  wire logic                          psel,
   input  wire logic                          penable,
   input  wire logic                          pwrite,
   input  wire logic [stsmc_pkg::ADDR_W-1:0]  paddr,
   input  wire logic [stsmc_pkg::DATA_W-1:0]  pwdata,
   output logic [stsmc_pkg::DATA_W-1:0]       prdata,
   output logic                               pready
);
   import stsmc_pkg::*;

   // The sequencer walks one request through these steps. Every Q16.16
   // product goes through the three multiply states, which split the left
   // operand at bit 16 so that the shared multiplier stays 23 by 32 bits.
   typedef enum logic [3:0] {
      ST_IDLE, ST_DIV, ST_ERR, ST_MUL_LO, ST_MUL_HI, ST_MUL_SUM, ST_SURF,
      ST_SQRT, ST_ROOT, ST_RINT, ST_SINT, ST_OUT
   } state_type;

   typedef enum logic [1:0] {OP_SURF, OP_ROOT1, OP_ROOT2, OP_SIGN} op_type;

   function automatic logic signed [31:0] sat32(input logic signed [55:0] x);
      if (x > 56'sd2147483647)
         return 32'sh7FFF_FFFF;
      else if (x < -56'sd2147483648)
         return 32'sh8000_0000;
      else
         return x[31:0];
   endfunction

   // Configuration registers.
   logic [DATA_W-1:0]   slope_ff, root_gain_ff, sign_gain_ff, low_lim_ff, high_lim_ff;
   logic [PERIOD_W-1:0] period_ff;
   logic                vel_mode_ff;
   logic [2:0]          csr_index;
   logic                csr_write;

   // Controller state and datapath.
   state_type           state_ff;
   op_type              op_ff;
   logic signed [31:0]  root_int_ff, sign_int_ff, prev_meas_ff;
   logic signed [31:0]  ref_ff, meas_ff, vel_ff, s_ff;
   logic                neg_ff, diff_neg_ff;
   logic [38:0]         qa_ff;
   logic [31:0]         qb_ff;
   logic [54:0]         prod_ff, acc_ff;
   logic                rsp_valid_ff;
   logic signed [31:0]  control_ff, surface_ff;

   logic                req_accept;
   logic [22:0]         mul_a;
   logic [54:0]         mul_p;
   logic [PERIOD_W-1:0] dt_eff, lambda_eff;
   logic [32:0]         alpha_eff;
   logic signed [32:0]  diff, err_wide;
   logic [31:0]         diff_mag;
   logic signed [31:0]  err;
   logic [31:0]         err_mag, slope_mag, s_mag;
   logic signed [47:0]  term;
   logic signed [31:0]  s_next;
   logic [40:0]         root_inc;
   logic signed [31:0]  root_next, sign_next;
   logic signed [32:0]  sum;
   logic signed [31:0]  control_next;
   logic                div_start, div_done, sqrt_start, sqrt_done;
   logic [DIVD_W-1:0]   div_q;
   logic [ROOT_W-1:0]   sqrt_root;
   logic signed [31:0]  vel_derived;
   logic                rsp_free;

   // Configuration port: always ready, written in the access phase.
   assign pready    = 1'b1;
   assign csr_index = paddr[4:2];
   assign csr_write = psel && penable && pwrite;

   always_comb begin
      prdata = '0;
      unique case (csr_index)
         REG_SLOPE:     prdata = slope_ff;
         REG_ROOT_GAIN: prdata = root_gain_ff;
         REG_SIGN_GAIN: prdata = sign_gain_ff;
         REG_PERIOD:    prdata = {1'b0, period_ff};
         REG_LOW_LIM:   prdata = low_lim_ff;
         REG_HIGH_LIM:  prdata = high_lim_ff;
         REG_VEL_MODE:  prdata = {31'd0, vel_mode_ff};
         default:       prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slope_ff     <= RST_SLOPE;
         root_gain_ff <= RST_ROOT_GAIN;
         sign_gain_ff <= RST_SIGN_GAIN;
         period_ff    <= RST_PERIOD;
         low_lim_ff   <= RST_LOW_LIM;
         high_lim_ff  <= RST_HIGH_LIM;
         vel_mode_ff  <= 1'b0;
      end else if (csr_write) begin
         unique case (csr_index)
            REG_SLOPE:     slope_ff     <= pwdata;
            REG_ROOT_GAIN: root_gain_ff <= pwdata;
            REG_SIGN_GAIN: sign_gain_ff <= pwdata;
            REG_PERIOD:    period_ff    <= pwdata[PERIOD_W-1:0];
            REG_LOW_LIM:   low_lim_ff   <= pwdata;
            REG_HIGH_LIM:  high_lim_ff  <= pwdata;
            REG_VEL_MODE:  vel_mode_ff  <= pwdata[0];
            default:       ;
         endcase
      end
   end

   // Effective gains and period. In difference mode a zero period falls back
   // to roughly one millisecond; with the velocity input it is used as it is.
   always_comb begin
      dt_eff     = (vel_mode_ff && period_ff == '0) ? FALLBACK_PERIOD : period_ff;
      lambda_eff = ($signed(root_gain_ff) <= 32'sd0) ? Q_ONE : root_gain_ff[PERIOD_W-1:0];
      if ($signed(sign_gain_ff) <= $signed({1'b0, lambda_eff}))
         alpha_eff = {1'b0, lambda_eff, 1'b0};
      else
         alpha_eff = {1'b0, sign_gain_ff};
   end

   assign req.ready  = (state_ff == ST_IDLE);
   assign req_accept = req.valid && req.ready;

   // The difference of measurements is formed straight from the request so
   // that the divider can start on the accepting edge.
   assign diff      = 33'(req.measurement) - 33'(prev_meas_ff);
   assign diff_mag  = diff[32] ? 32'(-diff) : diff[31:0];
   assign div_start = req_accept && vel_mode_ff;

   stsmc_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend ({1'b0, diff_mag, 16'd0}),
      .divisor  (dt_eff),
      .done     (div_done),
      .quotient (div_q)
   );

   // Any quotient of 2^31 or more saturates the derived velocity.
   always_comb begin
      if (div_q[DIVD_W-1:31] != '0)
         vel_derived = diff_neg_ff ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
      else
         vel_derived = diff_neg_ff ? -$signed(div_q[31:0]) : $signed(div_q[31:0]);
   end

   // Error and surface arithmetic.
   assign err_wide  = 33'(ref_ff) - 33'(meas_ff);
   assign err       = sat32(56'(err_wide));
   assign err_mag   = err[31] ? 32'(-err) : err;
   assign slope_mag = slope_ff[31] ? 32'(-$signed(slope_ff)) : slope_ff;
   assign term      = neg_ff ? -$signed({1'b0, acc_ff[46:0]}) : $signed({1'b0, acc_ff[46:0]});
   assign s_next    = sat32(56'(term) - 56'(vel_ff));
   assign s_mag     = s_next[31] ? 32'(-s_next) : s_next;
   assign sqrt_start = (state_ff == ST_SURF) && (s_next != 32'sd0);

   stsmc_sqrt u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (sqrt_start),
      .radicand ({s_mag, 16'd0}),
      .done     (sqrt_done),
      .root     (sqrt_root)
   );

   // Shared multiplier: low half of the left operand first, then the high half.
   assign mul_a = (state_ff == ST_MUL_LO) ? {7'd0, qa_ff[15:0]} : qa_ff[38:16];
   assign mul_p = 55'(mul_a) * 55'(qb_ff);

   // Integrator steps move against the sign of the surface.
   always_comb begin
      root_inc  = (acc_ff > 55'(41'h100_0000_0000)) ? 41'h100_0000_0000 : acc_ff[40:0];
      root_next = s_ff[31] ? sat32(56'(root_int_ff) + 56'(root_inc))
                           : sat32(56'(root_int_ff) - 56'(root_inc));
      sign_next = s_ff[31] ? sat32(56'(sign_int_ff) + 56'(acc_ff[48:0]))
                           : sat32(56'(sign_int_ff) - 56'(acc_ff[48:0]));
   end

   // With crossed limits the low test wins, as the clamp is applied in order.
   always_comb begin
      sum = 33'(root_int_ff) + 33'(sign_int_ff);
      if (sum < 33'($signed(low_lim_ff)))
         control_next = $signed(low_lim_ff);
      else if (sum > 33'($signed(high_lim_ff)))
         control_next = $signed(high_lim_ff);
      else
         control_next = sum[31:0];
   end

   assign rsp_free = !rsp_valid_ff || rsp.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         op_ff        <= OP_SURF;
         root_int_ff  <= '0;
         sign_int_ff  <= '0;
         prev_meas_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         // A new response is raised as the old one leaves, or the slot empties.
         if (state_ff == ST_OUT && rsp_free)
            rsp_valid_ff <= 1'b1;
         else if (rsp.ready)
            rsp_valid_ff <= 1'b0;
         unique case (state_ff)
            ST_IDLE: begin
               if (req_accept) begin
                  ref_ff      <= req.reference;
                  meas_ff     <= req.measurement;
                  vel_ff      <= req.velocity;
                  diff_neg_ff <= diff[32];
                  if (vel_mode_ff) begin
                     prev_meas_ff <= req.measurement;
                     state_ff     <= ST_DIV;
                  end else begin
                     state_ff <= ST_ERR;
                  end
               end
            end
            ST_DIV: begin
               if (div_done) begin
                  vel_ff   <= vel_derived;
                  state_ff <= ST_ERR;
               end
            end
            ST_ERR: begin
               qa_ff    <= 39'(slope_mag);
               qb_ff    <= err_mag;
               neg_ff   <= slope_ff[31] ^ err[31];
               op_ff    <= OP_SURF;
               state_ff <= ST_MUL_LO;
            end
            ST_MUL_LO: begin
               prod_ff  <= mul_p;
               state_ff <= ST_MUL_HI;
            end
            ST_MUL_HI: begin
               acc_ff   <= prod_ff >> 16;
               prod_ff  <= mul_p;
               state_ff <= ST_MUL_SUM;
            end
            ST_MUL_SUM: begin
               acc_ff <= acc_ff + prod_ff;
               unique case (op_ff)
                  OP_SURF:  state_ff <= ST_SURF;
                  OP_ROOT1: state_ff <= ST_ROOT;
                  OP_ROOT2: state_ff <= ST_RINT;
                  OP_SIGN:  state_ff <= ST_SINT;
                  default:  state_ff <= ST_IDLE;
               endcase
            end
            ST_SURF: begin
               // A zero surface leaves both integrators where they are.
               s_ff     <= s_next;
               state_ff <= (s_next == 32'sd0) ? ST_OUT : ST_SQRT;
            end
            ST_SQRT: begin
               if (sqrt_done) begin
                  qa_ff    <= 39'(lambda_eff);
                  qb_ff    <= 32'(sqrt_root);
                  op_ff    <= OP_ROOT1;
                  state_ff <= ST_MUL_LO;
               end
            end
            ST_ROOT: begin
               qa_ff    <= acc_ff[38:0];
               qb_ff    <= 32'(dt_eff);
               op_ff    <= OP_ROOT2;
               state_ff <= ST_MUL_LO;
            end
            ST_RINT: begin
               root_int_ff <= root_next;
               qa_ff       <= 39'(alpha_eff);
               qb_ff       <= 32'(dt_eff);
               op_ff       <= OP_SIGN;
               state_ff    <= ST_MUL_LO;
            end
            ST_SINT: begin
               sign_int_ff <= sign_next;
               state_ff    <= ST_OUT;
            end
            ST_OUT: begin
               if (rsp_free) begin
                  control_ff <= control_next;
                  surface_ff <= s_ff;
                  state_ff   <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign rsp.valid           = rsp_valid_ff;
   assign rsp.control         = control_ff;
   assign rsp.sliding_surface = surface_ff;

`ifndef SYNTHESIS
   // A request is only taken when the sequencer is idle, and it moves on.
   assert property (@(posedge clock) disable iff (reset)
      req_accept |=> state_ff != ST_IDLE)
      else $error("sequencer stayed idle after taking a request");

   // The divider only reports completion while the sequencer waits for it.
   assert property (@(posedge clock) disable iff (reset)
      div_done |-> state_ff == ST_DIV)
      else $error("divider finished outside its wait state");

   // A zero surface skips both integrator updates.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SURF && s_next == 32'sd0) |=>
         state_ff == ST_OUT && $stable(root_int_ff) && $stable(sign_int_ff))
      else $error("integrators moved on a zero surface");

   // The square-root unit only finishes while the sequencer waits for it.
   assert property (@(posedge clock) disable iff (reset)
      sqrt_done |-> state_ff == ST_SQRT)
      else $error("square root finished outside its wait state");
`endif

endmodule
`default_nettype wire

>>> bench/stsmc_checker.sv
// Checker that predicts and compares every response of the super-twisting controller.
`timescale 1ns / 100ps
module stsmc_checker (
   input  logic        clock,
   input  logic        reset,
   stsmc_req_if        req,
   stsmc_rsp_if        rsp,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [stsmc_pkg::ADDR_W-1:0] paddr,
   input  logic [31:0] pwdata,
   input  logic        pready,
   output int          outstanding,
   output int          failures
);
   import stsmc_pkg::*;

   typedef struct {
      logic [31:0] control;
      logic [31:0] sliding_surface;
   } ctrl_result_type;

   ctrl_result_type expected_outputs[$];

   logic [31:0] slope_reg, root_gain_reg, sign_gain_reg, low_lim_reg, high_lim_reg;
   logic [30:0] period_reg;
   logic        vel_mode_reg;
   longint      root_acc, sign_acc, last_meas;

   function automatic longint sext(logic [31:0] x);
      return longint'(signed'(x));
   endfunction

   function automatic longint sat32(longint x);
      if (x > 64'sd2147483647) return 64'sd2147483647;
      if (x < -64'sd2147483648) return -64'sd2147483648;
      return x;
   endfunction

   function automatic longint unsigned magnitude(longint x);
      return (x < 0) ? longint'(-x) : longint'(x);
   endfunction

   // Q16.16 product on magnitudes, truncated.
   function automatic longint unsigned qmul(longint unsigned a, longint unsigned b);
      return (a >> 16) * b + (((a & 64'hFFFF) * b) >> 16);
   endfunction

   function automatic longint unsigned floor_sqrt(longint unsigned x);
      longint unsigned r;
      longint unsigned bitv;
      r = 0;
      bitv = 64'd1 << 62;
      while (bitv > x) bitv = bitv >> 2;
      while (bitv != 0) begin
         if (x >= r + bitv) begin
            x = x - (r + bitv);
            r = (r >> 1) + bitv;
         end else begin
            r = r >> 1;
         end
         bitv = bitv >> 2;
      end
      return r;
   endfunction

   task automatic step_controller(input logic [31:0] rf, input logic [31:0] ms,
                                  input logic [31:0] vl);
      longint r, y, v, dt, lam, alp, slope, lo, hi, diff, err, term, s, sum;
      longint unsigned q, tm, sq, inc;
      ctrl_result_type res;
      r = sext(rf);
      y = sext(ms);
      v = sext(vl);
      dt = longint'(period_reg);
      lam = sext(root_gain_reg);
      alp = sext(sign_gain_reg);
      slope = sext(slope_reg);
      lo = sext(low_lim_reg);
      hi = sext(high_lim_reg);
      if (vel_mode_reg) begin
         diff = y - last_meas;
         if (dt == 0) dt = longint'(FALLBACK_PERIOD);
         q = (magnitude(diff) << 16) / longint'(dt);
         if (q > 64'd4294967296) q = 64'd4294967296;
         v = sat32(diff < 0 ? -longint'(q) : longint'(q));
         last_meas = y;
      end
      err = sat32(r - y);
      tm = qmul(magnitude(slope), magnitude(err));
      term = ((slope < 0) != (err < 0)) ? -longint'(tm) : longint'(tm);
      s = sat32(term - v);
      if (lam <= 0) lam = longint'(Q_ONE);
      if (alp <= lam) alp = 2 * lam;
      if (s != 0) begin
         sq = floor_sqrt(magnitude(s) << 16);
         inc = qmul(qmul(longint'(lam), sq), longint'(dt));
         if (inc > (64'd1 << 40)) inc = 64'd1 << 40;
         root_acc = sat32(s > 0 ? root_acc - longint'(inc) : root_acc + longint'(inc));
         inc = qmul(longint'(alp), longint'(dt));
         sign_acc = sat32(s > 0 ? sign_acc - longint'(inc) : sign_acc + longint'(inc));
      end
      sum = root_acc + sign_acc;
      if (sum < lo) sum = lo;
      else if (sum > hi) sum = hi;
      res.control = sum[31:0];
      res.sliding_surface = s[31:0];
      expected_outputs.push_back(res);
   endtask

   initial begin
      failures = 0;
      outstanding = 0;
   end

   always @(posedge clock) begin
      ctrl_result_type want;
      if (reset) begin
         slope_reg <= RST_SLOPE;
         root_gain_reg <= RST_ROOT_GAIN;
         sign_gain_reg <= RST_SIGN_GAIN;
         period_reg <= RST_PERIOD;
         low_lim_reg <= RST_LOW_LIM;
         high_lim_reg <= RST_HIGH_LIM;
         vel_mode_reg <= 1'b0;
         root_acc = 0;
         sign_acc = 0;
         last_meas = 0;
         expected_outputs.delete();
      end else begin
         if (psel && penable && pwrite && pready) begin
            case (paddr >> 2)
               REG_SLOPE:     slope_reg <= pwdata;
               REG_ROOT_GAIN: root_gain_reg <= pwdata;
               REG_SIGN_GAIN: sign_gain_reg <= pwdata;
               REG_PERIOD:    period_reg <= pwdata[30:0];
               REG_LOW_LIM:   low_lim_reg <= pwdata;
               REG_HIGH_LIM:  high_lim_reg <= pwdata;
               REG_VEL_MODE:  vel_mode_reg <= pwdata[0];
               default: ;
            endcase
         end
         if (req.valid && req.ready)
            step_controller(req.reference, req.measurement, req.velocity);
         if (rsp.valid && rsp.ready) begin
            if (expected_outputs.size() == 0) begin
               $error("response with no request waiting: control %h surface %h",
                      rsp.control, rsp.sliding_surface);
               failures++;
            end else begin
               want = expected_outputs.pop_front();
               if (rsp.control !== want.control) begin
                  $error("control: expected %h, actual %h", want.control, rsp.control);
                  failures++;
               end
               if (rsp.sliding_surface !== want.sliding_surface) begin
                  $error("sliding_surface: expected %h, actual %h",
                         want.sliding_surface, rsp.sliding_surface);
                  failures++;
               end
            end
         end
      end
      outstanding = expected_outputs.size();
   end
endmodule

>>> bench/testbench.sv
// Top of the bench: clock, reset, stimulus and verdict for the super-twisting controller.
`timescale 1ns / 100ps
module testbench;
   import stsmc_pkg::*;

   localparam int PHASES          = 10;
   localparam int ITEMS_PER_PHASE = 113;
   localparam int HOLD_CYCLES     = 400;

   logic clock;
   logic reset;
   logic psel, penable, pwrite;
   logic [ADDR_W-1:0] paddr;
   logic [31:0] pwdata;
   logic [31:0] prdata;
   logic pready;
   int outstanding;
   int failures;

   // When calm is set neither side idles; hold_response asks the receiver
   // for one long stall so that the block backs up into its request side.
   bit calm;
   bit hold_response;

   stsmc_req_if req_if ();
   stsmc_rsp_if rsp_if ();

   super_twisting_sliding_mode_control dut (
      .clock   (clock),
      .reset   (reset),
      .req     (req_if),
      .rsp     (rsp_if),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   stsmc_checker checker_i (
      .clock       (clock),
      .reset       (reset),
      .req         (req_if),
      .rsp         (rsp_if),
      .psel        (psel),
      .penable     (penable),
      .pwrite      (pwrite),
      .paddr       (paddr),
      .pwdata      (pwdata),
      .pready      (pready),
      .outstanding (outstanding),
      .failures    (failures)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // The slowest correct run is far below this; it only catches a hang.
   initial begin
      #12_000_000;
      $display("CHECKS FAILED");
      $finish;
   end

   // Receiver side: random stalls, one long hold on request, none when calm.
   initial begin
      forever begin
         if (hold_response) begin
            rsp_if.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_response = 1'b0;
         end else if (!calm && $urandom_range(0, 5) == 0) begin
            rsp_if.ready <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge clock);
         end else begin
            rsp_if.ready <= 1'b1;
            @(posedge clock);
         end
      end
   end

   // A register write has a setup phase and an access phase; the register
   // is loaded at the edge that closes the access phase.
   task automatic write_reg(input reg_index_type idx, input logic [31:0] value);
      @(posedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= ADDR_W'(idx) << 2;
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
   endtask

   // Drives one request and returns once it has been accepted. The valid
   // line is only lowered when a gap follows, so it never toggles twice in
   // one step.
   task automatic send_request(input logic [31:0] rf, input logic [31:0] ms,
                               input logic [31:0] vl);
      bit taken;
      req_if.valid       <= 1'b1;
      req_if.reference   <= rf;
      req_if.measurement <= ms;
      req_if.velocity    <= vl;
      taken = 1'b0;
      while (!taken) begin
         @(posedge clock);
         taken = req_if.ready;
      end
      if (!calm && $urandom_range(0, 3) == 0) begin
         req_if.valid <= 1'b0;
         repeat ($urandom_range(1, 14)) @(posedge clock);
      end
   endtask

   // Field values: mostly small or full-range, with the extremes now and then.
   function automatic logic [31:0] pick_value();
      case ($urandom_range(0, 7))
         0: return 32'h8000_0000;
         1: return 32'h7FFF_FFFF;
         2, 3, 4: return 32'($signed($urandom_range(0, 32'h0020_0000)) - 32'sh0010_0000);
         default: return $urandom();
      endcase
   endfunction

   // The first edge lets the checker count the request taken just before.
   task automatic drain();
      req_if.valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic set_phase(input int phase);
      logic [31:0] lo, hi;
      case (phase)
         0: begin
            write_reg(REG_SLOPE, 32'h0001_0000);
            write_reg(REG_ROOT_GAIN, 32'h0001_8000);
            write_reg(REG_SIGN_GAIN, 32'h0004_0000);
            write_reg(REG_PERIOD, 32'd66);
            write_reg(REG_LOW_LIM, 32'hFF9C_0000);
            write_reg(REG_HIGH_LIM, 32'h0064_0000);
            write_reg(REG_VEL_MODE, 32'd1);
         end
         1: begin
            // Gain guards both active; a zero period with the velocity input
            // leaves the integrators where they are.
            write_reg(REG_SLOPE, 32'h7FFF_FFFF);
            write_reg(REG_ROOT_GAIN, 32'd0);
            write_reg(REG_SIGN_GAIN, 32'd0);
            write_reg(REG_PERIOD, 32'd0);
            write_reg(REG_VEL_MODE, 32'd0);
         end
         2: begin
            // Zero period in difference mode falls back to the default step.
            write_reg(REG_SLOPE, 32'h8000_0000);
            write_reg(REG_ROOT_GAIN, 32'h8000_0000);
            write_reg(REG_SIGN_GAIN, 32'h7FFF_FFFF);
            write_reg(REG_VEL_MODE, 32'd1);
         end
         3: begin
            // Crossed limits, the largest period and the largest lambda.
            write_reg(REG_ROOT_GAIN, 32'h7FFF_FFFF);
            write_reg(REG_SIGN_GAIN, 32'h8000_0000);
            write_reg(REG_PERIOD, 32'h7FFF_FFFF);
            write_reg(REG_LOW_LIM, 32'h0064_0000);
            write_reg(REG_HIGH_LIM, 32'hFF9C_0000);
            write_reg(REG_VEL_MODE, 32'd0);
         end
         4: begin
            write_reg(REG_SLOPE, 32'h0002_0000);
            write_reg(REG_ROOT_GAIN, 32'h0000_8000);
            write_reg(REG_SIGN_GAIN, 32'h0001_0000);
            write_reg(REG_PERIOD, 32'h0001_0000);
            write_reg(REG_LOW_LIM, 32'h8000_0000);
            write_reg(REG_HIGH_LIM, 32'h7FFF_FFFF);
            write_reg(REG_VEL_MODE, 32'd1);
         end
         default: begin
            lo = $urandom();
            hi = $urandom();
            if ($urandom_range(0, 2) != 0 && $signed(lo) > $signed(hi)) begin
               lo = lo ^ hi;
               hi = lo ^ hi;
               lo = lo ^ hi;
            end
            write_reg(REG_SLOPE, pick_value());
            write_reg(REG_ROOT_GAIN, $urandom_range(0, 3) == 0 ? $urandom()
                                                               : $urandom_range(1, 32'h0008_0000));
            write_reg(REG_SIGN_GAIN, $urandom_range(0, 3) == 0 ? $urandom()
                                                               : $urandom_range(1, 32'h0010_0000));
            write_reg(REG_PERIOD, $urandom_range(0, 3) == 0 ? $urandom()
                                                            : $urandom_range(0, 4000));
            write_reg(REG_LOW_LIM, lo);
            write_reg(REG_HIGH_LIM, hi);
            write_reg(REG_VEL_MODE, $urandom_range(0, 1));
         end
      endcase
   endtask

   initial begin
      logic [31:0] meas;
      calm          = 1'b0;
      hold_response = 1'b0;
      reset         <= 1'b1;
      psel          <= 1'b0;
      penable       <= 1'b0;
      pwrite        <= 1'b0;
      paddr         <= '0;
      pwdata        <= '0;
      req_if.valid       <= 1'b0;
      req_if.reference   <= '0;
      req_if.measurement <= '0;
      req_if.velocity    <= '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed requests under the reset settings: field extremes, a zero
      // surface, and saturation of the error and of the surface.
      send_request(32'd0, 32'd0, 32'd0);
      send_request(32'h0001_0000, 32'h0001_0000, 32'd0);
      send_request(32'h7FFF_FFFF, 32'h8000_0000, 32'd0);
      send_request(32'h8000_0000, 32'h7FFF_FFFF, 32'd0);
      send_request(32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000);
      send_request(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
      send_request(32'd0, 32'd0, 32'h7FFF_FFFF);
      send_request(32'd0, 32'd0, 32'h8000_0000);
      send_request(32'hFFFF_FFFF, 32'd0, 32'd0);
      send_request(32'd1, 32'd0, 32'd0);
      send_request(32'h0001_0000, 32'd0, 32'h0001_0000);
      send_request(32'd0, 32'd0, 32'd1);
      send_request(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      for (int i = 0; i < 6; i++)
         send_request(32'h7FFF_FFFF, 32'd0, 32'h8000_0000);
      drain();

      for (int phase = 0; phase < PHASES; phase++) begin
         set_phase(phase);
         if (phase == 4) hold_response = 1'b1;
         if (phase == PHASES - 1) calm = 1'b1;
         meas = pick_value();
         for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
            // Measurements mostly move in small steps, as a plant would, so
            // that the finite difference stays in range; some jump anywhere.
            if ($urandom_range(0, 4) == 0) meas = pick_value();
            else meas = meas + 32'($signed($urandom_range(0, 8192)) - 4096);
            send_request(pick_value(), meas, pick_value());
         end
         drain();
      end

      repeat (200) @(posedge clock);
      if (failures == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end
endmodule
